### rtl/cps_pkg.sv
// Shared widths, defaults and request/result types for the column projection segmenter.
package cps_pkg;

    localparam int PIXEL_W        = 8;
    localparam int COL_W          = 10;
    localparam int ROW_W          = 8;
    localparam int ORDER_W        = 10;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 256;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               column_end;
        logic               image_end;
    } t_pix_req;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [COL_W-1:0]   start_x;
        logic [COL_W-1:0]   end_x;
        logic [ROW_W-1:0]   start_y;
        logic [ROW_W-1:0]   end_y;
    } t_result;

endpackage

### rtl/cps_in_stage.sv
// Input register that holds one pixel request until the tracker takes it.
module cps_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cps_pkg::t_pix_req i_req,
    input  logic              i_advance,
    output logic              o_valid,
    output cps_pkg::t_pix_req o_req
);
    import cps_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_pix_req r_req;
    logic     accept;

    assign o_ready = !r_valid || i_advance;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

### rtl/cps_tracker.sv
// Column/row position tracking and run bounding box, one pixel per cycle unless the output register is held.
module cps_tracker #(
    parameter int MAX_WIDTH  = cps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cps_pkg::DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cps_pkg::t_pix_req i_req,
    input  logic              i_out_free,
    output logic              o_advance,
    output logic              o_emit,
    output cps_pkg::t_result  o_result
);
    import cps_pkg::*;

    localparam int COL_LIMIT_I = (MAX_WIDTH - 1 < 1023) ? MAX_WIDTH - 1 : 1023;
    localparam int ROW_LIMIT_I = (MAX_HEIGHT - 1 < 255) ? MAX_HEIGHT - 1 : 255;
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COL_LIMIT_I);
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROW_LIMIT_I);
    localparam logic [ROW_W-1:0] TOP_RESET = {ROW_W{1'b1}};

    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_col_black, n_col_black;
    logic               r_open, n_open;
    logic [COL_W-1:0]   r_first, n_first;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [ROW_W-1:0]   r_bottom, n_bottom;
    logic [ORDER_W-1:0] r_found, n_found;

    logic               black;
    logic               col_end;
    logic               img_end;
    logic               start_run;
    logic               upd_col_black;
    logic               upd_open;
    logic [COL_W-1:0]   upd_first;
    logic [ROW_W-1:0]   top_base;
    logic [ROW_W-1:0]   bottom_base;
    logic [ROW_W-1:0]   upd_top;
    logic [ROW_W-1:0]   upd_bottom;
    logic               emit;
    logic [COL_W-1:0]   last_col;
    logic [ORDER_W-1:0] order_inc;

    always_comb begin
        black         = (i_req.pixel == '0);
        img_end       = i_req.image_end;
        col_end       = i_req.column_end || img_end;
        start_run     = black && !r_open;
        upd_col_black = r_col_black || black;
        upd_open      = r_open || black;
        upd_first     = start_run ? r_col : r_first;
        top_base      = start_run ? TOP_RESET : r_top;
        bottom_base   = start_run ? '0 : r_bottom;
        upd_top       = (black && (r_row < top_base)) ? r_row : top_base;
        upd_bottom    = (black && (r_row > bottom_base)) ? r_row : bottom_base;

        // a black-free column closes the run, and so does the image end
        emit = col_end && upd_open && (!upd_col_black || img_end);
        if (!upd_col_black) begin
            last_col = (r_col > upd_first) ? r_col - 1'b1 : upd_first;
        end else begin
            last_col = r_col;
        end
        order_inc = r_found + 1'b1;
    end

    assign o_advance = i_valid && (!emit || i_out_free);
    assign o_emit    = o_advance && emit;

    assign o_result.order   = order_inc;
    assign o_result.start_x = upd_first;
    assign o_result.end_x   = last_col;
    assign o_result.start_y = upd_top;
    assign o_result.end_y   = upd_bottom;

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_col_black = upd_col_black;
        n_open      = upd_open;
        n_first     = upd_first;
        n_top       = upd_top;
        n_bottom    = upd_bottom;
        n_found     = r_found;
        if (col_end) begin
            n_col_black = 1'b0;
            n_row       = '0;
            if (emit) begin
                n_found  = order_inc;
                n_open   = 1'b0;
                n_first  = '0;
                n_top    = TOP_RESET;
                n_bottom = '0;
            end
            if (img_end) begin
                n_col    = '0;
                n_found  = '0;
                n_open   = 1'b0;
                n_first  = '0;
                n_top    = TOP_RESET;
                n_bottom = '0;
            end else if (r_col < COL_LIMIT) begin
                n_col = r_col + 1'b1;
            end
        end else if (r_row < ROW_LIMIT) begin
            n_row = r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_col_black <= 1'b0;
            r_open      <= 1'b0;
            r_first     <= '0;
            r_top       <= TOP_RESET;
            r_bottom    <= '0;
            r_found     <= '0;
        end else if (o_advance) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_col_black <= n_col_black;
            r_open      <= n_open;
            r_first     <= n_first;
            r_top       <= n_top;
            r_bottom    <= n_bottom;
            r_found     <= n_found;
        end
    end

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LIMIT)
        else $error("column index beyond limit");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_LIMIT)
        else $error("row index beyond limit");

    a_closed_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_top == TOP_RESET && r_bottom == '0 && r_first == '0))
        else $error("closed run holds stale bounds");

    a_image_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && i_req.image_end) |=> (r_col == '0 && r_found == '0 && !r_open))
        else $error("image end did not restart tracking");

    a_emit_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (r_open || black))
        else $error("result without an open run");

endmodule

### rtl/cps_out_stage.sv
// Result register toward the output channel.
module cps_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cps_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output cps_pkg::t_result o_result
);
    import cps_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && r_valid && !i_ready))
        else $error("result register overwritten while held");

endmodule

### rtl/column_projection_segmenter.sv
// Column projection segmenter: top level joining input, tracker and result stages.
// Pixels arrive in column-major order, one request per cycle; a pixel of value 0 is
// black. Each run of adjacent columns holding black is reported once, when a black-free
// column or the image end closes it, with its number from 1, first and last column and
// topmost and bottommost black rows. The block takes one pixel every cycle; the closing
// pixel is held in the input register and its result is then loaded into the output
// register. Intake pauses only when a closing pixel meets a result still held in the
// output register, since that register is the single slot for results. MAX_WIDTH and
// MAX_HEIGHT set where the column and row counters saturate.
module column_projection_segmenter #(
    parameter int MAX_WIDTH  = cps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cps_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cps_pkg::PIXEL_W-1:0] i_pixel,
    input  logic                        i_column_end,
    input  logic                        i_image_end,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cps_pkg::ORDER_W-1:0] o_order,
    output logic [cps_pkg::COL_W-1:0]   o_start_x,
    output logic [cps_pkg::COL_W-1:0]   o_end_x,
    output logic [cps_pkg::ROW_W-1:0]   o_start_y,
    output logic [cps_pkg::ROW_W-1:0]   o_end_y
);
    import cps_pkg::*;

    t_pix_req in_req;
    t_pix_req stage_req;
    logic     stage_valid;
    logic     advance;
    logic     emit;
    logic     out_free;
    t_result  trk_result;
    t_result  out_result;

    assign in_req.pixel      = i_pixel;
    assign in_req.column_end = i_column_end;
    assign in_req.image_end  = i_image_end;

    cps_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (in_req),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_req     (stage_req)
    );

    cps_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_trk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stage_valid),
        .i_req      (stage_req),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_emit     (emit),
        .o_result   (trk_result)
    );

    cps_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (trk_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_order   = out_result.order;
    assign o_start_x = out_result.start_x;
    assign o_end_x   = out_result.end_x;
    assign o_start_y = out_result.start_y;
    assign o_end_y   = out_result.end_y;

endmodule
